### src/qsv_pkg.sv
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared types, codes and constants of the state-vector gate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qsv_pkg;

	localparam int AMP_FRAC_BITS  = 16;
	localparam int AMP_W          = AMP_FRAC_BITS + 2;
	localparam int COEF_W         = 2 * AMP_W;
	localparam int NORM_W         = 48;
	localparam int MAX_QUBITS_DEF = 10;
	localparam int QDEPTH         = 2;
	localparam int QPW            = $clog2(QDEPTH);

	localparam logic [3:0] QC_RESET = 4'd10;

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_GATE  = 3'd1;
	localparam logic [2:0] OP_SWAP  = 3'd2;
	localparam logic [2:0] OP_NORM  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [2:0] K_NOP   = 3'd0;
	localparam logic [2:0] K_CLEAR = 3'd1;
	localparam logic [2:0] K_GATE  = 3'd2;
	localparam logic [2:0] K_SWAP  = 3'd3;
	localparam logic [2:0] K_NORM  = 3'd4;
	localparam logic [2:0] K_READ  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_OVERLAP = 2'd2;

	typedef struct packed {
		logic [2:0]        kind;
		logic [1:0]        status;
		logic [3:0]        tq;
		logic [3:0]        sq;
		logic [9:0]        cm;
		logic [9:0]        idx;
		logic [COEF_W-1:0] c00;
		logic [COEF_W-1:0] c01;
		logic [COEF_W-1:0] c10;
		logic [COEF_W-1:0] c11;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [17:0]       re;
		logic [17:0]       im;
		logic [NORM_W-1:0] norm;
	} res_t;

endpackage

`default_nettype wire

### src/qubit_state_vector_gate_engine.sv
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine
// State-vector gate engine with a 2^n complex amplitude store.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready/s_tdata, one operation per beat;
// every beat yields one result beat on m_tvalid/m_tready/m_tdata.
// The qcount register (APB addresses 0 to 3) is to be written by the user
// only while idle; the block itself does not enforce this. A write reloads
// basis state zero into the store.
// Per updated pair a gate makes two reads, four multiply/sum steps of four
// 18x18 products and two writes; a swap makes two reads and two writes per
// moved pair. Gate, swap and norm scan the 2^n indices in use; clear sweeps
// the whole 2^MAX_QUBITS store, as does the reload after a qcount write.
// After reset the store sweeps 2^MAX_QUBITS entries to load basis state zero;
// beats are queued meanwhile. A two-entry command queue lets the input side
// keep accepting while the back works; when m_tready is low the finished
// result holds in the output register and the back waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module qubit_state_vector_gate_engine #(
	parameter int MAX_QUBITS = qsv_pkg::MAX_QUBITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// operation, target_qubit, second_qubit, ctrl_mask, amp_index,
	// coef_00, coef_01, coef_10, coef_11, zero pad
	input  wire logic [175:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, amp_real, amp_imag, norm_sq, zero pad
	output logic [87:0]       m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import qsv_pkg::*;

	logic [3:0] qc_q, eff_n;
	logic       cfg_wr;
	logic       push, pop, q_full, q_empty;
	cmd_t       f_cmd, q_cmd;
	res_t       res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = {28'd0, qc_q};
	assign eff_n  = (32'(qc_q) > MAX_QUBITS) ? 4'(MAX_QUBITS) : qc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qc_q <= QC_RESET;
		else if (cfg_wr) qc_q <= pwdata[3:0];
	end

	qsv_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.eff_n    (eff_n),
		.q_full   (q_full),
		.push     (push),
		.cmd      (f_cmd)
	);

	qsv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (f_cmd),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.cmd_out (q_cmd)
	);

	qsv_back #(.MAX_QUBITS(MAX_QUBITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_n    (eff_n),
		.cfg_wr   (cfg_wr),
		.q_empty  (q_empty),
		.q_cmd    (q_cmd),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {2'b00, res.norm, res.im, res.re, res.status};

endmodule

`default_nettype wire

### src/qsv_front.sv
// ----------------------------------------------------------------------------
// qsv_front
// Accepts input beats, checks qubit indices, control mask and amplitude index,
// and classifies the operation.
`default_nettype none

module qsv_front (
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [175:0]   s_tdata,
	input  wire logic [3:0]     eff_n,
	input  wire logic           q_full,
	output logic                push,
	output qsv_pkg::cmd_t       cmd
);
	import qsv_pkg::*;

	logic [2:0]  op;
	logic [3:0]  tq, sq;
	logic [9:0]  cm, idx;
	logic [16:0] size;
	logic        cm_hi, tq_bad, sq_bad, cm_on_t, cm_on_s;

	assign op  = s_tdata[2:0];
	assign tq  = s_tdata[6:3];
	assign sq  = s_tdata[10:7];
	assign cm  = s_tdata[20:11];
	assign idx = s_tdata[30:21];

	assign size    = 17'd1 << eff_n;
	assign cm_hi   = (cm >> eff_n) != 10'd0;
	assign tq_bad  = tq >= eff_n;
	assign sq_bad  = sq >= eff_n;
	assign cm_on_t = (cm & (10'd1 << tq)) != 10'd0;
	assign cm_on_s = (cm & (10'd1 << sq)) != 10'd0;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		cmd.status = ST_OK;
		cmd.kind   = K_NOP;
		cmd.tq     = tq;
		cmd.sq     = sq;
		cmd.cm     = cm;
		cmd.idx    = idx;
		cmd.c00    = s_tdata[66:31];
		cmd.c01    = s_tdata[102:67];
		cmd.c10    = s_tdata[138:103];
		cmd.c11    = s_tdata[174:139];
		case (op)
			OP_CLEAR: cmd.kind = K_CLEAR;
			OP_GATE: begin
				if (tq_bad || cm_hi) cmd.status = ST_RANGE;
				else if (cm_on_t) cmd.status = ST_OVERLAP;
				else cmd.kind = K_GATE;
			end
			OP_SWAP: begin
				if (tq_bad || sq_bad) cmd.status = ST_RANGE;
				else if (tq == sq) cmd.kind = K_NOP;
				else if (cm_hi) cmd.status = ST_RANGE;
				else if (cm_on_t || cm_on_s) cmd.status = ST_OVERLAP;
				else cmd.kind = K_SWAP;
			end
			OP_NORM: cmd.kind = K_NORM;
			OP_READ: begin
				if ({7'd0, idx} >= size) cmd.status = ST_RANGE;
				else cmd.kind = K_READ;
			end
			default: cmd.kind = K_NOP;
		endcase
	end

endmodule

`default_nettype wire

### src/qsv_queue.sv
// ----------------------------------------------------------------------------
// qsv_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire qsv_pkg::cmd_t cmd_in,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output qsv_pkg::cmd_t      cmd_out
);
	import qsv_pkg::*;

	cmd_t           ent_q [QDEPTH];
	logic [QPW-1:0] wptr_q, rptr_q;
	logic [QPW:0]   cnt_q;

	assign full    = cnt_q == (QPW+1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign cmd_out = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### src/qsv_back.sv
// ----------------------------------------------------------------------------
// qsv_back
// Amplitude store and sequencer: clear, gate, swap, norm and read.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_back #(
	parameter int MAX_QUBITS = qsv_pkg::MAX_QUBITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [3:0]    eff_n,
	input  wire logic          cfg_wr,
	input  wire logic          q_empty,
	input  wire qsv_pkg::cmd_t q_cmd,
	output logic               q_pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output qsv_pkg::res_t      res
);
	import qsv_pkg::*;

	localparam int AW    = MAX_QUBITS;
	localparam int DEPTH = 1 << AW;
	localparam int PW    = 2 * AMP_W + 1 - AMP_FRAC_BITS;
	localparam int SW    = PW + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_PB     = 4'd3;
	localparam logic [3:0] S_PC     = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_ACC    = 4'd6;
	localparam logic [3:0] S_W0     = 4'd7;
	localparam logic [3:0] S_W1     = 4'd8;
	localparam logic [3:0] S_NORM   = 4'd9;
	localparam logic [3:0] S_NDRAIN = 4'd10;
	localparam logic [3:0] S_RDA    = 4'd11;
	localparam logic [3:0] S_RDB    = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	localparam logic [AW-1:0]     ONE_A   = 1;
	localparam logic [COEF_W-1:0] AMP_ONE = COEF_W'(1) << (AMP_FRAC_BITS + AMP_W);
	localparam logic signed [AMP_W-1:0] AMP_HI = {1'b0, {(AMP_W-1){1'b1}}};
	localparam logic signed [AMP_W-1:0] AMP_LO = {1'b1, {(AMP_W-1){1'b0}}};
	localparam logic signed [2*AMP_W:0] RND = (2*AMP_W+1)'(1) << (AMP_FRAC_BITS - 1);

	logic [COEF_W-1:0] mem [DEPTH];
	logic [COEF_W-1:0] rdata_q;
	logic [AW-1:0]     raddr, waddr;
	logic [COEF_W-1:0] wdata;
	logic              mem_we;

	logic [3:0]        state_q;
	logic [AW:0]       cnt_q;
	logic [AW:0]       size;
	cmd_t              cmd_q;
	logic              clr_pend_q, clr_cmd_q;
	logic [COEF_W-1:0] a0_q, a1_q, new0_q, new1_q;
	logic [AW-1:0]     j_q;
	logic [1:0]        ph_q;
	logic signed [PW-1:0] prod_q [4];
	res_t              res_q;
	logic              out_valid_q;
	logic [NORM_W-1:0] norm_q;
	logic              rv_s1, sv_s2;
	logic [2*AMP_W:0]  sq_s2;

	logic [AW-1:0] i, bit_t, bit_s, cm_a, k, j;
	logic          gate_hit, swap_hit, hit;

	assign size  = (AW+1)'(1) << eff_n;
	assign i     = cnt_q[AW-1:0];
	assign bit_t = ONE_A << cmd_q.tq;
	assign bit_s = ONE_A << cmd_q.sq;
	assign cm_a  = AW'(cmd_q.cm);
	assign k     = i ^ (bit_t | bit_s);

	assign gate_hit = ((i & bit_t) == '0) && ((i & cm_a) == cm_a);
	assign swap_hit = ((i & cm_a) == cm_a) && (((i & bit_t) != '0) != ((i & bit_s) != '0))
		&& (k > i);
	assign hit = (cmd_q.kind == K_GATE) ? gate_hit : swap_hit;
	assign j   = (cmd_q.kind == K_GATE) ? (i | bit_t) : k;

	// product selection for one part of the new pair
	logic [COEF_W-1:0]  ca, cb;
	logic signed [AMP_W-1:0] cra, cia, crb, cib, x0, y0, x1, y1;
	logic signed [2*AMP_W:0] m [4];

	assign ca  = ph_q[1] ? cmd_q.c10 : cmd_q.c00;
	assign cb  = ph_q[1] ? cmd_q.c11 : cmd_q.c01;
	assign cra = ca[COEF_W-1:AMP_W];
	assign cia = ca[AMP_W-1:0];
	assign crb = cb[COEF_W-1:AMP_W];
	assign cib = cb[AMP_W-1:0];
	assign x0  = ph_q[0] ? a0_q[AMP_W-1:0] : a0_q[COEF_W-1:AMP_W];
	assign y0  = ph_q[0] ? a0_q[COEF_W-1:AMP_W] : a0_q[AMP_W-1:0];
	assign x1  = ph_q[0] ? a1_q[AMP_W-1:0] : a1_q[COEF_W-1:AMP_W];
	assign y1  = ph_q[0] ? a1_q[COEF_W-1:AMP_W] : a1_q[AMP_W-1:0];

	always_comb begin
		m[0] = (2*AMP_W+1)'(cra * x0) + RND;
		m[1] = (2*AMP_W+1)'(cia * y0) + RND;
		m[2] = (2*AMP_W+1)'(crb * x1) + RND;
		m[3] = (2*AMP_W+1)'(cib * y1) + RND;
	end

	logic signed [SW-1:0]    psum;
	logic signed [AMP_W-1:0] part;

	always_comb begin
		if (ph_q[0]) psum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
		else psum = SW'(prod_q[0]) - SW'(prod_q[1]) + SW'(prod_q[2]) - SW'(prod_q[3]);
		if (psum > SW'(AMP_HI)) part = AMP_HI;
		else if (psum < SW'(AMP_LO)) part = AMP_LO;
		else part = psum[AMP_W-1:0];
	end

	// memory ports
	always_comb begin
		raddr  = i;
		waddr  = i;
		wdata  = new0_q;
		mem_we = 1'b0;
		case (state_q)
			S_PB: raddr = j_q;
			S_RDA: raddr = AW'(cmd_q.idx);
			S_CLR: begin
				mem_we = 1'b1;
				wdata  = (i == '0) ? AMP_ONE : '0;
			end
			S_W0: mem_we = 1'b1;
			S_W1: begin
				mem_we = 1'b1;
				waddr  = j_q;
				wdata  = new1_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// norm pipeline
	logic signed [AMP_W-1:0] nre, nim;
	logic [NORM_W:0]         nsum;

	assign nre  = rdata_q[COEF_W-1:AMP_W];
	assign nim  = rdata_q[AMP_W-1:0];
	assign nsum = {1'b0, norm_q} + (NORM_W+1)'(sq_s2);

	always_ff @(posedge clk) begin
		sq_s2 <= (2*AMP_W+1)'(nre * nre) + (2*AMP_W+1)'(nim * nim);
	end

	assign q_pop    = (state_q == S_IDLE) && !clr_pend_q && !cfg_wr && !q_empty;
	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_pend_q  <= 1'b0;
			clr_cmd_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
			sv_s2       <= 1'b0;
			ph_q        <= '0;
		end else begin
			rv_s1 <= (state_q == S_NORM) && (cnt_q != size);
			sv_s2 <= rv_s1;
			if (cfg_wr && (state_q != S_IDLE)) clr_pend_q <= 1'b1;
			else if (state_q == S_IDLE) clr_pend_q <= 1'b0;
			if ((state_q == S_DONE) && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (clr_pend_q || cfg_wr) begin
						clr_cmd_q  <= 1'b0;
						cnt_q      <= '0;
						state_q    <= S_CLR;
					end else if (!q_empty) begin
						cnt_q <= '0;
						case (q_cmd.kind)
							K_CLEAR: begin
								clr_cmd_q <= 1'b1;
								state_q   <= S_CLR;
							end
							K_GATE: state_q <= S_SCAN;
							K_SWAP: state_q <= S_SCAN;
							K_NORM: state_q <= S_NORM;
							K_READ: state_q <= S_RDA;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (i == {AW{1'b1}}) state_q <= clr_cmd_q ? S_DONE : S_IDLE;
				end
				S_SCAN: begin
					if (cnt_q == size) state_q <= S_DONE;
					else if (hit) begin
						j_q     <= j;
						state_q <= S_PB;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_PB: state_q <= S_PC;
				S_PC: begin
					ph_q <= '0;
					if (cmd_q.kind == K_SWAP) state_q <= S_W0;
					else state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					ph_q <= ph_q + 1'b1;
					state_q <= (ph_q == 2'd3) ? S_W0 : S_MUL;
				end
				S_W0: state_q <= S_W1;
				S_W1: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_NORM: begin
					if (cnt_q == size) state_q <= S_NDRAIN;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_NDRAIN: begin
					if (!rv_s1 && !sv_s2) state_q <= S_DONE;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sv_s2) norm_q <= nsum[NORM_W] ? {NORM_W{1'b1}} : nsum[NORM_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					cmd_q         <= q_cmd;
					norm_q        <= '0;
					out_q.status  <= q_cmd.status;
					out_q.re      <= '0;
					out_q.im      <= '0;
					out_q.norm    <= '0;
				end
			end
			S_PB: a0_q <= rdata_q;
			S_PC: begin
				a1_q   <= rdata_q;
				new0_q <= rdata_q;
				new1_q <= a0_q;
			end
			S_MUL: begin
				prod_q[0] <= PW'(m[0] >>> AMP_FRAC_BITS);
				prod_q[1] <= PW'(m[1] >>> AMP_FRAC_BITS);
				prod_q[2] <= PW'(m[2] >>> AMP_FRAC_BITS);
				prod_q[3] <= PW'(m[3] >>> AMP_FRAC_BITS);
			end
			S_ACC: begin
				case (ph_q)
					2'd0: new0_q[COEF_W-1:AMP_W] <= part;
					2'd1: new0_q[AMP_W-1:0] <= part;
					2'd2: new1_q[COEF_W-1:AMP_W] <= part;
					default: new1_q[AMP_W-1:0] <= part;
				endcase
			end
			S_NDRAIN: out_q.norm <= norm_q;
			S_RDB: begin
				out_q.re <= 18'(signed'(rdata_q[COEF_W-1:AMP_W]));
				out_q.im <= 18'(signed'(rdata_q[AMP_W-1:0]));
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) res_q <= out_q;
			end
			default: out_q <= out_q;
		endcase
	end

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE))
		else $error("command popped while busy");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("store written while idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[AW] |-> (cnt_q[AW-1:0] == '0))
		else $error("index counter beyond store depth");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !out_valid_q |=> out_valid_q)
		else $error("result not loaded");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the state-vector gate engine: a directed table
// followed by random operations over several qubit counts and idle patterns,
// each result beat compared with a table entry or an in-bench model of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import qsv_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam int     HOLD_CYCLES = 4000;

	typedef struct {
		logic [2:0]        op;
		logic [3:0]        tq;
		logic [3:0]        sq;
		logic [9:0]        cm;
		logic [9:0]        idx;
		logic [COEF_W-1:0] c00, c01, c10, c11;
	} op_item_t;

	typedef struct {
		logic [1:0]        status;
		logic [17:0]       re;
		logic [17:0]       im;
		logic [NORM_W-1:0] norm;
	} op_res_t;

	typedef struct {
		op_item_t item;
		bit       fixed;
		op_res_t  res;
	} dir_row_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [175:0] s_tdata;
	logic [87:0]  m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;

	qubit_state_vector_gate_engine uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [COEF_W-1:0] amp_model [1024];
	logic [3:0]        qc_model;
	op_res_t           pending_res [$];
	int                errors = 0;
	longint            cyc = 0;
	bit                send_gaps = 0, recv_stalls = 0;
	int                idle_pct = 58;
	int                hold_reqs = 0, hold_seen = 0, hold_left = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// receiver: long hold-off on request, else random stalls when enabled
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (recv_stalls) begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		op_res_t want, got;
		if (m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.re     = m_tdata[19:2];
			got.im     = m_tdata[37:20];
			got.norm   = m_tdata[85:38];
			if (pending_res.size() == 0) begin
				$display("%0t unexpected result beat %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_res.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.re !== want.re) begin
					$display("%0t amp_real exp %h got %h", $time, want.re, got.re);
					errors++;
				end
				if (got.im !== want.im) begin
					$display("%0t amp_imag exp %h got %h", $time, want.im, got.im);
					errors++;
				end
				if (got.norm !== want.norm) begin
					$display("%0t norm_sq exp %h got %h", $time, want.norm, got.norm);
					errors++;
				end
			end
		end
	end

	function automatic longint re_of(logic [COEF_W-1:0] e);
		return longint'($signed(e[COEF_W-1:AMP_W]));
	endfunction

	function automatic longint im_of(logic [COEF_W-1:0] e);
		return longint'($signed(e[AMP_W-1:0]));
	endfunction

	function automatic longint rnd_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< (AMP_FRAC_BITS - 1))) >>> AMP_FRAC_BITS;
	endfunction

	function automatic logic [AMP_W-1:0] clamp_amp(longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (AMP_W - 1)) - 1;
		lo = -(64'sd1 <<< (AMP_W - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[AMP_W-1:0];
	endfunction

	function automatic logic [COEF_W-1:0] cmul_add(logic [COEF_W-1:0] c0, a0, c1, a1);
		longint r, m;
		r = rnd_mul(re_of(c0), re_of(a0)) - rnd_mul(im_of(c0), im_of(a0))
			+ rnd_mul(re_of(c1), re_of(a1)) - rnd_mul(im_of(c1), im_of(a1));
		m = rnd_mul(re_of(c0), im_of(a0)) + rnd_mul(im_of(c0), re_of(a0))
			+ rnd_mul(re_of(c1), im_of(a1)) + rnd_mul(im_of(c1), re_of(a1));
		return {clamp_amp(r), clamp_amp(m)};
	endfunction

	function automatic void load_ground();
		foreach (amp_model[i]) amp_model[i] = '0;
		amp_model[0] = {18'sd65536, 18'd0};
	endfunction

	function automatic int qubits_in_use();
		return (qc_model > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(qc_model);
	endfunction

	function automatic op_res_t apply_op(op_item_t it);
		op_res_t r;
		int n, sz, k;
		longint a, b;
		logic [COEF_W-1:0] a0, a1, t;
		logic [9:0] bt, bs;
		logic [NORM_W:0] acc;
		n = qubits_in_use();
		sz = 1 << n;
		r = '{default: '0};
		case (it.op)
			OP_CLEAR: load_ground();
			OP_GATE: begin
				if (it.tq >= n || (it.cm >> n) != 0) begin
					r.status = ST_RANGE;
				end else if (it.cm[it.tq]) begin
					r.status = ST_OVERLAP;
				end else begin
					bt = 10'd1 << it.tq;
					for (int i = 0; i < sz; i++) begin
						if ((i & bt) != 0 || (i & it.cm) != it.cm) continue;
						a0 = amp_model[i];
						a1 = amp_model[i | bt];
						amp_model[i]      = cmul_add(it.c00, a0, it.c01, a1);
						amp_model[i | bt] = cmul_add(it.c10, a0, it.c11, a1);
					end
				end
			end
			OP_SWAP: begin
				if (it.tq >= n || it.sq >= n) begin
					r.status = ST_RANGE;
				end else if (it.tq != it.sq) begin
					bt = 10'd1 << it.tq;
					bs = 10'd1 << it.sq;
					if ((it.cm >> n) != 0) begin
						r.status = ST_RANGE;
					end else if ((it.cm & (bt | bs)) != 0) begin
						r.status = ST_OVERLAP;
					end else begin
						for (int i = 0; i < sz; i++) begin
							if ((i & it.cm) != it.cm) continue;
							k = i;
							if (((i & bt) != 0) != ((i & bs) != 0)) k = i ^ (bt | bs);
							if (k <= i) continue;
							t = amp_model[i];
							amp_model[i] = amp_model[k];
							amp_model[k] = t;
						end
					end
				end
			end
			OP_NORM: begin
				acc = '0;
				for (int i = 0; i < sz; i++) begin
					a = re_of(amp_model[i]);
					b = im_of(amp_model[i]);
					acc = acc + (a * a) + (b * b);
					if (acc[NORM_W]) acc = {1'b0, {NORM_W{1'b1}}};
				end
				r.norm = acc[NORM_W-1:0];
			end
			OP_READ: begin
				if (it.idx >= sz) begin
					r.status = ST_RANGE;
				end else begin
					r.re = amp_model[it.idx][COEF_W-1:AMP_W];
					r.im = amp_model[it.idx][AMP_W-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_op(op_item_t it, bit fixed, op_res_t fixed_res);
		op_res_t p;
		if (send_gaps) begin
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.c11, it.c10, it.c01, it.c00, it.idx, it.cm, it.sq, it.tq, it.op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = apply_op(it);
		pending_res.push_back(fixed ? fixed_res : p);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		qc_model = data[3:0];
		load_ground();
	endtask

	function automatic logic [COEF_W-1:0] pick_coef();
		logic [AMP_W-1:0] vals [7];
		vals = '{18'h10000, 18'h30000, 18'h0B505, 18'h34AFB, 18'h0, 18'h1FFFF, 18'h20000};
		if ($urandom_range(1)) return {$urandom(), $urandom()};
		return {vals[$urandom_range(6)], vals[$urandom_range(6)]};
	endfunction

	function automatic op_item_t rand_op();
		op_item_t it;
		int n, w;
		n = qubits_in_use();
		w = $urandom_range(99);
		it.op = (w < 45) ? OP_GATE : (w < 65) ? OP_SWAP : (w < 75) ? OP_NORM :
			(w < 94) ? OP_READ : (w < 96) ? OP_CLEAR : 3'($urandom_range(7));
		it.tq  = ($urandom_range(9) == 0 || n == 0) ? 4'($urandom()) : 4'($urandom_range(n - 1));
		it.sq  = ($urandom_range(9) == 0 || n == 0) ? 4'($urandom()) : 4'($urandom_range(n - 1));
		it.cm  = 10'($urandom()) & 10'((1 << n) - 1);
		if ($urandom_range(1)) it.cm = it.cm & 10'($urandom());
		if ($urandom_range(3) != 0) it.cm = it.cm & ~((10'd1 << it.tq) | (10'd1 << it.sq));
		if ($urandom_range(11) == 0) it.cm = 10'($urandom());
		it.idx = ($urandom_range(7) == 0) ? 10'($urandom()) : 10'($urandom_range((1 << n) - 1));
		it.c00 = pick_coef();
		it.c01 = pick_coef();
		it.c10 = pick_coef();
		it.c11 = pick_coef();
		return it;
	endfunction

	localparam logic [COEF_W-1:0] ONE  = {18'h10000, 18'h0};
	localparam logic [COEF_W-1:0] HALF = {18'h0B505, 18'h0};
	localparam logic [COEF_W-1:0] NHLF = {18'h34AFB, 18'h0};
	localparam logic [COEF_W-1:0] ZERO = '0;
	localparam logic [COEF_W-1:0] ALL1 = '1;
	localparam logic [COEF_W-1:0] PMAX = {18'h1FFFF, 18'h1FFFF};

	dir_row_t dir_rows [] = '{
		'{'{OP_READ,  0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 18'h10000, 0, 0}},
		'{'{OP_NORM,  0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 48'h1_0000_0000}},
		'{'{OP_READ,  0, 0, 0,    1023, ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 0}},
		'{'{3'd5,     0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 0}},
		'{'{3'd7,     15, 15, 1023, 1023, ALL1, ALL1, ALL1, ALL1}, 1, '{ST_OK, 0, 0, 0}},
		'{'{OP_GATE,  10, 0, 0,   0,    ONE,  ZERO, ZERO, ONE }, 1, '{ST_RANGE, 0, 0, 0}},
		'{'{OP_GATE,  15, 0, 0,   0,    ONE,  ZERO, ZERO, ONE }, 1, '{ST_RANGE, 0, 0, 0}},
		'{'{OP_GATE,  2,  0, 4,   0,    ONE,  ZERO, ZERO, ONE }, 1, '{ST_OVERLAP, 0, 0, 0}},
		'{'{OP_SWAP,  3,  12, 0,  0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_RANGE, 0, 0, 0}},
		'{'{OP_SWAP,  1,  1, 2,   0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 0}},
		'{'{OP_SWAP,  0,  1, 1,   0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OVERLAP, 0, 0, 0}},
		'{'{OP_READ,  0, 0, 0,    1023, ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 0}},
		'{'{OP_GATE,  0, 0, 0,    0,    HALF, HALF, HALF, NHLF}, 0, '{default: 0}},
		'{'{OP_GATE,  9, 0, 1,    0,    HALF, HALF, HALF, NHLF}, 0, '{default: 0}},
		'{'{OP_READ,  0, 0, 0,    1,    ZERO, ZERO, ZERO, ZERO}, 0, '{default: 0}},
		'{'{OP_READ,  0, 0, 0,    513,  ZERO, ZERO, ZERO, ZERO}, 0, '{default: 0}},
		'{'{OP_SWAP,  0, 9, 2,    0,    ZERO, ZERO, ZERO, ZERO}, 0, '{default: 0}},
		'{'{OP_GATE,  1, 0, 0,    0,    PMAX, PMAX, PMAX, PMAX}, 0, '{default: 0}},
		'{'{OP_GATE,  3, 0, 0,    0,    ALL1, ALL1, ALL1, ALL1}, 0, '{default: 0}},
		'{'{OP_NORM,  0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 0, '{default: 0}},
		'{'{OP_READ,  0, 0, 0,    2,    ZERO, ZERO, ZERO, ZERO}, 0, '{default: 0}},
		'{'{OP_CLEAR, 0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 0, 0, 0}},
		'{'{OP_READ,  0, 0, 0,    0,    ZERO, ZERO, ZERO, ZERO}, 1, '{ST_OK, 18'h10000, 0, 0}}
	};

	logic [3:0] phase_qc    [10] = '{4'd3, 4'd0, 4'd15, 4'd5, 4'd1, 4'd4, 4'd10, 4'd2, 4'd6, 4'd3};
	int         phase_items [10] = '{140, 60, 12, 150, 120, 200, 10, 150, 160, 150};

	initial begin
		op_res_t none;
		none = '{default: '0};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		qc_model = QC_RESET;
		load_ground();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_op(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);
		drain();

		foreach (phase_qc[p]) begin
			apb_write(3'd0, {28'd0, phase_qc[p]});
			send_gaps   = (p % 4 == 1) || (p % 4 == 3);
			recv_stalls = (p % 4 == 2) || (p % 4 == 3);
			idle_pct    = (p % 4 == 3) ? 17 : 58;
			if (p == 3) hold_reqs++;
			for (int k = 0; k < phase_items[p]; k++) send_op(rand_op(), 0, none);
			drain();
		end

		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

### qubit_state_vector_gate_engine.f
src/qsv_pkg.sv
src/qsv_front.sv
src/qsv_queue.sv
src/qsv_back.sv
src/qubit_state_vector_gate_engine.sv
test/tb.sv
